>>> design/stq_pkg.sv
// Package with the constants, codes and types shared by the sorted timer queue.
package stq_pkg;

    localparam int CAPACITY = 16;

    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADJUST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd5;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [HANDLE_W-1:0]   handle;
        logic [TIME_W-1:0]     expiry;
        logic [TIME_W-1:0]     now_time;
    } t_cell_cmd;

    typedef struct packed {
        logic                  valid;
        logic [TIME_W-1:0]     expiry;
        logic [HANDLE_W-1:0]   handle;
    } t_entry;

endpackage

>>> design/stq_cell.sv
// One storage cell of the sorted timer chain, shifting entries to or from its neighbours.
module stq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stq_pkg::t_cell_cmd i_cmd,
    input  stq_pkg::t_entry   i_left,
    input  stq_pkg::t_entry   i_right,
    input  logic              i_ins_left,
    input  logic              i_rm_left,
    output stq_pkg::t_entry   o_entry,
    output logic              o_ins,
    output logic              o_rm,
    output logic              o_match,
    output logic              o_le
);

    logic                          r_valid;
    logic [stq_pkg::TIME_W-1:0]    r_expiry;
    logic [stq_pkg::HANDLE_W-1:0]  r_handle;
    logic                          n_valid;
    logic [stq_pkg::TIME_W-1:0]    n_expiry;
    logic [stq_pkg::HANDLE_W-1:0]  n_handle;
    logic                          w_after;

    assign w_after = !r_valid || (r_expiry > i_cmd.expiry);
    assign o_match = r_valid && (r_handle == i_cmd.handle);
    assign o_le    = r_valid && (r_expiry <= i_cmd.now_time);
    assign o_ins   = i_ins_left || w_after;
    assign o_rm    = i_rm_left || o_match;

    assign o_entry.valid  = r_valid;
    assign o_entry.expiry = r_expiry;
    assign o_entry.handle = r_handle;

    always_comb begin
        n_valid  = r_valid;
        n_expiry = r_expiry;
        n_handle = r_handle;
        unique case (i_cmd.op)
            stq_pkg::CELL_INSERT: begin
                if (i_ins_left) begin
                    n_valid  = i_left.valid;
                    n_expiry = i_left.expiry;
                    n_handle = i_left.handle;
                end else if (w_after) begin
                    n_valid  = 1'b1;
                    n_expiry = i_cmd.expiry;
                    n_handle = i_cmd.handle;
                end
            end
            stq_pkg::CELL_REMOVE: begin
                if (o_rm) begin
                    n_valid  = i_right.valid;
                    n_expiry = i_right.expiry;
                    n_handle = i_right.handle;
                end
            end
            stq_pkg::CELL_SHIFT: begin
                n_valid  = i_right.valid;
                n_expiry = i_right.expiry;
                n_handle = i_right.handle;
            end
            stq_pkg::CELL_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_expiry <= n_expiry;
        r_handle <= n_handle;
    end

endmodule

>>> design/sorted_timer_queue.sv
// Top level of the sorted timer queue: command sequencer over a chain of timer cells.
//
//   Channel   Handshake                 Payload
//   command   start, busy               i_kind, i_handle, i_expiry, i_now_time
//   result    o_strobe (one cycle)      o_out_handle, o_status, o_last
//
// A transaction is taken when start is high and busy is low; busy then stays high until the
// final result has been presented. An adjust makes a removal pass then an insertion pass
// through the cell chain, and a tick gives one result per expired timer (or one none result),
// as the chain hands one expired head per cycle to the output.
// Reset clears every cell's valid bit in the same cycle, so no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sorted_timer_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [stq_pkg::KIND_W-1:0]     i_kind,
    input  logic [stq_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [stq_pkg::TIME_W-1:0]     i_expiry,
    input  logic [stq_pkg::TIME_W-1:0]     i_now_time,
    output logic                           o_strobe,
    output logic [stq_pkg::HANDLE_W-1:0]   o_out_handle,
    output logic [stq_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_INS,
        S_TICK
    } t_state;

    t_state                          r_state;
    logic [stq_pkg::KIND_W-1:0]      r_kind;
    logic [stq_pkg::HANDLE_W-1:0]    r_handle;
    logic [stq_pkg::TIME_W-1:0]      r_expiry;
    logic [stq_pkg::TIME_W-1:0]      r_now_time;
    logic                            r_strobe;
    logic [stq_pkg::HANDLE_W-1:0]    r_out_handle;
    logic [stq_pkg::STATUS_W-1:0]    r_status;
    logic                            r_last;

    stq_pkg::t_cell_cmd              w_cmd;
    stq_pkg::t_entry                 w_entry [stq_pkg::CAPACITY];
    logic [stq_pkg::CAPACITY-1:0]    w_ins;
    logic [stq_pkg::CAPACITY-1:0]    w_rm;
    logic [stq_pkg::CAPACITY-1:0]    w_match;
    logic [stq_pkg::CAPACITY-1:0]    w_le;
    logic [stq_pkg::CAPACITY-1:0]    w_valid;
    logic                            w_found;
    logic                            w_full;

    genvar g;
    generate
        for (g = 0; g < stq_pkg::CAPACITY; g++) begin : g_cell
            stq_pkg::t_entry w_left;
            stq_pkg::t_entry w_right;
            logic            w_ins_left;
            logic            w_rm_left;

            if (g == 0) begin : g_head
                assign w_left     = '0;
                assign w_ins_left = 1'b0;
                assign w_rm_left  = 1'b0;
            end else begin : g_body
                assign w_left     = w_entry[g-1];
                assign w_ins_left = w_ins[g-1];
                assign w_rm_left  = w_rm[g-1];
            end

            if (g == stq_pkg::CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            stq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_ins_left (w_ins_left),
                .i_rm_left  (w_rm_left),
                .o_entry    (w_entry[g]),
                .o_ins      (w_ins[g]),
                .o_rm       (w_rm[g]),
                .o_match    (w_match[g]),
                .o_le       (w_le[g])
            );

            assign w_valid[g] = w_entry[g].valid;
        end
    endgenerate

    assign w_found = |w_match;
    assign w_full  = w_valid[stq_pkg::CAPACITY-1];

    always_comb begin
        w_cmd.op       = stq_pkg::CELL_HOLD;
        w_cmd.handle   = r_handle;
        w_cmd.expiry   = r_expiry;
        w_cmd.now_time = r_now_time;
        unique case (r_state)
            S_OP: begin
                unique case (r_kind)
                    stq_pkg::KIND_ADD: begin
                        if (!w_found && !w_full) begin
                            w_cmd.op = stq_pkg::CELL_INSERT;
                        end
                    end
                    stq_pkg::KIND_ADJUST, stq_pkg::KIND_DELETE: begin
                        if (w_found) begin
                            w_cmd.op = stq_pkg::CELL_REMOVE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                w_cmd.op = stq_pkg::CELL_INSERT;
            end
            S_TICK: begin
                if (w_le[0]) begin
                    w_cmd.op = stq_pkg::CELL_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (start) begin
                        r_kind     <= i_kind;
                        r_handle   <= i_handle;
                        r_expiry   <= i_expiry;
                        r_now_time <= i_now_time;
                        r_state    <= (i_kind == stq_pkg::KIND_TICK) ? S_TICK : S_OP;
                    end
                end
                S_OP: begin
                    r_out_handle <= r_handle;
                    r_last       <= 1'b1;
                    unique case (r_kind)
                        stq_pkg::KIND_ADD: begin
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                            if (w_found) begin
                                r_status <= stq_pkg::ST_DUP;
                            end else if (w_full) begin
                                r_status <= stq_pkg::ST_FULL;
                            end else begin
                                r_status <= stq_pkg::ST_DONE;
                            end
                        end
                        stq_pkg::KIND_ADJUST: begin
                            if (w_found) begin
                                r_strobe <= 1'b0;
                                r_state  <= S_INS;
                            end else begin
                                r_strobe <= 1'b1;
                                r_state  <= S_IDLE;
                                r_status <= stq_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                            r_status <= w_found ? stq_pkg::ST_DONE : stq_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
                S_INS: begin
                    r_out_handle <= r_handle;
                    r_status     <= stq_pkg::ST_DONE;
                    r_last       <= 1'b1;
                    r_strobe     <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_TICK: begin
                    r_strobe <= 1'b1;
                    if (w_le[0]) begin
                        r_out_handle <= w_entry[0].handle;
                        r_status     <= stq_pkg::ST_EXPIRED;
                        r_last       <= !w_le[1];
                        if (!w_le[1]) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_out_handle <= '0;
                        r_status     <= stq_pkg::ST_NONE;
                        r_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_out_handle = r_out_handle;
    assign o_status     = r_status;
    assign o_last       = r_last;

    // Stored timers always occupy a contiguous run of cells from the head.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + stq_pkg::CAPACITY'(1)) & w_valid) == '0)
        else $error("timer cells are not contiguous from the head");

    // The final result of a transaction returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy still high after the final result");

    // An expired result that is not the last is followed at once by another result.
    a_tick_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last && o_status == stq_pkg::ST_EXPIRED) |=> o_strobe)
        else $error("gap in a run of expired results");

    // Only expired results can leave a transaction unfinished.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != stq_pkg::ST_EXPIRED) |-> o_last)
        else $error("non-expiry result without the last flag");

endmodule

>>> verif/sorted_timer_queue_tb.sv
// Self-checking testbench for the sorted timer queue, driving directed and random timer operations.
module sorted_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [stq_pkg::HANDLE_W-1:0] handle;
        logic [stq_pkg::STATUS_W-1:0] status;
        logic                         last;
    } t_timer_result;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         start      = 1'b0;
    logic                         busy;
    logic [stq_pkg::KIND_W-1:0]   i_kind     = '0;
    logic [stq_pkg::HANDLE_W-1:0] i_handle   = '0;
    logic [stq_pkg::TIME_W-1:0]   i_expiry   = '0;
    logic [stq_pkg::TIME_W-1:0]   i_now_time = '0;
    logic                         o_strobe;
    logic [stq_pkg::HANDLE_W-1:0] o_out_handle;
    logic [stq_pkg::STATUS_W-1:0] o_status;
    logic                         o_last;

    logic [stq_pkg::TIME_W-1:0]   timer_expiry [stq_pkg::CAPACITY];
    logic [stq_pkg::HANDLE_W-1:0] timer_handle [stq_pkg::CAPACITY];
    int                           timer_count = 0;
    t_timer_result                pending_results [$];

    int fail_count  = 0;
    int idle_cycles = 0;
    int n_ops       = 0;
    int n_expired   = 0;
    int max_drain   = 0;
    int kind_seen   [4] = '{default: 0};
    int status_seen [8] = '{default: 0};

    sorted_timer_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_handle     (i_handle),
        .i_expiry     (i_expiry),
        .i_now_time   (i_now_time),
        .o_strobe     (o_strobe),
        .o_out_handle (o_out_handle),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int find_timer(input logic [stq_pkg::HANDLE_W-1:0] h);
        for (int i = 0; i < timer_count; i++) begin
            if (timer_handle[i] == h) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void remove_timer(input int pos);
        for (int i = pos; i + 1 < timer_count; i++) begin
            timer_expiry[i] = timer_expiry[i+1];
            timer_handle[i] = timer_handle[i+1];
        end
        timer_count--;
    endfunction

    function automatic void place_timer(input logic [stq_pkg::HANDLE_W-1:0] h,
                                        input logic [stq_pkg::TIME_W-1:0] e);
        int pos;
        pos = 0;
        while (pos < timer_count && timer_expiry[pos] <= e) begin
            pos++;
        end
        for (int i = timer_count; i > pos; i--) begin
            timer_expiry[i] = timer_expiry[i-1];
            timer_handle[i] = timer_handle[i-1];
        end
        timer_expiry[pos] = e;
        timer_handle[pos] = h;
        timer_count++;
    endfunction

    function automatic void expect_result(input logic [stq_pkg::HANDLE_W-1:0] h,
                                          input logic [stq_pkg::STATUS_W-1:0] st,
                                          input logic last);
        t_timer_result r;
        r.handle = h;
        r.status = st;
        r.last   = last;
        pending_results.push_back(r);
        status_seen[st]++;
    endfunction

    function automatic void predict_timer_op(input logic [stq_pkg::KIND_W-1:0] kind,
                                             input logic [stq_pkg::HANDLE_W-1:0] h,
                                             input logic [stq_pkg::TIME_W-1:0] e,
                                             input logic [stq_pkg::TIME_W-1:0] now);
        int pos;
        int drained;
        pos     = find_timer(h);
        drained = 0;
        case (kind)
            stq_pkg::KIND_ADD: begin
                if (pos >= 0) begin
                    expect_result(h, stq_pkg::ST_DUP, 1'b1);
                end else if (timer_count >= stq_pkg::CAPACITY) begin
                    expect_result(h, stq_pkg::ST_FULL, 1'b1);
                end else begin
                    place_timer(h, e);
                    expect_result(h, stq_pkg::ST_DONE, 1'b1);
                end
            end
            stq_pkg::KIND_ADJUST, stq_pkg::KIND_DELETE: begin
                if (pos < 0) begin
                    expect_result(h, stq_pkg::ST_NOTFOUND, 1'b1);
                end else begin
                    remove_timer(pos);
                    if (kind == stq_pkg::KIND_ADJUST) begin
                        place_timer(h, e);
                    end
                    expect_result(h, stq_pkg::ST_DONE, 1'b1);
                end
            end
            stq_pkg::KIND_TICK: begin
                while (timer_count > 0 && timer_expiry[0] <= now) begin
                    expect_result(timer_handle[0], stq_pkg::ST_EXPIRED,
                                  timer_count == 1 || timer_expiry[1] > now);
                    remove_timer(0);
                    drained++;
                end
                if (drained == 0) begin
                    expect_result('0, stq_pkg::ST_NONE, 1'b1);
                end
                n_expired += drained;
                if (drained > max_drain) begin
                    max_drain = drained;
                end
            end
        endcase
    endfunction

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_kind     <= stq_pkg::KIND_W'($urandom);
            i_handle   <= stq_pkg::HANDLE_W'($urandom);
            i_expiry   <= $urandom;
            i_now_time <= $urandom;
        end
    endtask

    task automatic send_timer_op(input logic [stq_pkg::KIND_W-1:0] kind,
                                 input logic [stq_pkg::HANDLE_W-1:0] h,
                                 input logic [stq_pkg::TIME_W-1:0] e,
                                 input logic [stq_pkg::TIME_W-1:0] now,
                                 input int gap);
        hold_off(gap);
        @(negedge i_clk);
        start      <= 1'b1;
        i_kind     <= kind;
        i_handle   <= h;
        i_expiry   <= e;
        i_now_time <= now;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        predict_timer_op(kind, h, e, now);
        n_ops++;
        kind_seen[kind]++;
    endtask

    task automatic wait_for_results();
        hold_off(1);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [stq_pkg::HANDLE_W-1:0] fresh_handle();
        logic [stq_pkg::HANDLE_W-1:0] h;
        do begin
            h = stq_pkg::HANDLE_W'($urandom);
        end while (find_timer(h) >= 0);
        return h;
    endfunction

    task automatic test_directed();
        send_timer_op(stq_pkg::KIND_TICK,   16'h0000, 32'd0,        32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADD,    16'h0000, 32'd0,        32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADD,    16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADD,    16'h1234, 32'd100,      32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADD,    16'h5678, 32'd100,      32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADD,    16'h1234, 32'd7,        32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADJUST, 16'h0BAD, 32'd5,        32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_DELETE, 16'h0BAD, 32'd0,        32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADJUST, 16'h0000, 32'd100,      32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_ADJUST, 16'hFFFF, 32'd50,       32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_TICK,   16'h0000, 32'd0,        32'd99,
                      random_gap());
        send_timer_op(stq_pkg::KIND_DELETE, 16'h5678, 32'd0,        32'd0,
                      random_gap());
        send_timer_op(stq_pkg::KIND_TICK,   16'h0000, 32'd0,        32'hFFFFFFFF,
                      random_gap());
        send_timer_op(stq_pkg::KIND_TICK,   16'h0000, 32'd0,        32'd0,
                      random_gap());
    endtask

    task automatic test_full_store();
        while (timer_count < stq_pkg::CAPACITY) begin
            send_timer_op(stq_pkg::KIND_ADD, fresh_handle(), 32'd1000 + $urandom_range(0, 5),
                          32'd0, random_gap());
        end
        send_timer_op(stq_pkg::KIND_ADD, fresh_handle(), 32'd0, 32'd0, random_gap());
        send_timer_op(stq_pkg::KIND_ADD, timer_handle[$urandom_range(0, stq_pkg::CAPACITY - 1)],
                      32'd3, 32'd0, random_gap());
        send_timer_op(stq_pkg::KIND_ADJUST, timer_handle[0], 32'd1002, 32'd0, random_gap());
        send_timer_op(stq_pkg::KIND_TICK, fresh_handle(), 32'd0, 32'hFFFFFFFF, random_gap());
    endtask

    task automatic test_random(input int count);
        int                           r;
        int                           gap;
        bit                           no_idle;
        logic [stq_pkg::KIND_W-1:0]   kind;
        logic [stq_pkg::HANDLE_W-1:0] h;
        logic [stq_pkg::TIME_W-1:0]   e;
        logic [stq_pkg::TIME_W-1:0]   now;
        logic [stq_pkg::TIME_W-1:0]   cur_time;
        cur_time = $urandom_range(0, 1000);
        no_idle  = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (i == count / 2) begin
                wait_for_results();
            end
            r   = $urandom_range(0, 99);
            h   = fresh_handle();
            e   = cur_time + $urandom_range(0, 300);
            now = cur_time;
            if (r < 40) begin
                kind = stq_pkg::KIND_ADD;
                if (timer_count > 0 && $urandom_range(0, 4) == 0) begin
                    h = timer_handle[$urandom_range(0, timer_count - 1)];
                end
            end else if (r < 72) begin
                kind = (r < 58) ? stq_pkg::KIND_ADJUST : stq_pkg::KIND_DELETE;
                if (timer_count > 0 && $urandom_range(0, 6) != 0) begin
                    h = timer_handle[$urandom_range(0, timer_count - 1)];
                end
            end else begin
                kind     = stq_pkg::KIND_TICK;
                now      = cur_time + $urandom_range(0, 60);
                cur_time = now;
            end
            if ($urandom_range(0, 19) == 0) begin
                e   = $urandom;
                now = (kind == stq_pkg::KIND_TICK) ? $urandom : now;
            end
            gap = no_idle ? 0 : random_gap();
            send_timer_op(kind, h, e, now, gap);
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: out_handle %h status %0d last %b",
                       o_out_handle, o_status, o_last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_handle !== want.handle) begin
                    $error("out_handle: expected %h, got %h", want.handle, o_out_handle);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe === 1'b1 || (start && busy === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_store();
        test_random(300);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d operations: %0d add, %0d adjust, %0d delete, %0d tick.",
                 n_ops, kind_seen[stq_pkg::KIND_ADD], kind_seen[stq_pkg::KIND_ADJUST],
                 kind_seen[stq_pkg::KIND_DELETE], kind_seen[stq_pkg::KIND_TICK]);
        $display("Expired %0d timers, longest drain %0d; full %0d, not found %0d, duplicate %0d.",
                 n_expired, max_drain, status_seen[stq_pkg::ST_FULL],
                 status_seen[stq_pkg::ST_NOTFOUND], status_seen[stq_pkg::ST_DUP]);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
